// ===== rtl/core/rpi_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, types and state codes for the RGB palette indexer.
// No dependencies; every other file of the block imports this package.
package rpi_pkg;

  localparam int CHAN_W               = 8;
  localparam int COLOR_W              = 3 * CHAN_W;
  localparam int IDX_OUT_W            = 8;
  localparam int CNT_OUT_W            = 9;
  localparam int PALETTE_SIZE_DEFAULT = 256;

  // Search word that travels along the row of palette cells.
  typedef struct packed {
    logic                 active;
    logic [COLOR_W-1:0]   color;
    logic                 hit;
    logic [IDX_OUT_W-1:0] index;
  } probe_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] color_index;
    logic                 is_new_color;
    logic                 overflow;
    logic [CNT_OUT_W-1:0] color_count;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } ctrl_state_t;

endpackage

// ===== rtl/core/rpi_pixel_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel that carries one RGB pixel word.
// Depends on rpi_pkg for the channel width.
interface rpi_pixel_if;
  import rpi_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              first_pixel;

  modport source (output valid, red, green, blue, first_pixel, input ready);
  modport sink   (input valid, red, green, blue, first_pixel, output ready);
endinterface

// ===== rtl/core/rpi_result_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel that carries one indexed-colour result word.
// Depends on rpi_pkg for the field widths.
interface rpi_result_if;
  import rpi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] color_index;
  logic                 is_new_color;
  logic                 overflow;
  logic [CNT_OUT_W-1:0] color_count;

  modport source (output valid, color_index, is_new_color, overflow, color_count,
                  input ready);
  modport sink   (input valid, color_index, is_new_color, overflow, color_count,
                  output ready);
endinterface

// ===== rtl/core/rpi_cell.sv =====
`timescale 1ns / 1ps
// One palette cell: holds a single colour entry, compares the passing probe
// against it and appends the colour when it is the next free slot. Uses rpi_pkg.
module rpi_cell #(
  parameter int CELL_ID = 0,
  parameter int CNT_W   = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rpi_pkg::probe_t       probe_in,
  input  logic [CNT_W-1:0]      count,
  output rpi_pkg::probe_t       probe_out
);
  import rpi_pkg::*;

  localparam logic [CNT_W-1:0]     ID_CNT = CNT_W'(CELL_ID);
  localparam logic [IDX_OUT_W-1:0] ID_IDX = IDX_OUT_W'(CELL_ID);

  logic [COLOR_W-1:0] entry;
  logic               searching;
  logic               match;
  logic               append;
  probe_t             probe_next;

  assign searching = probe_in.active && !probe_in.hit;
  // Only cells below the fill count hold colours of the current palette.
  assign match     = searching && (ID_CNT < count) && (entry == probe_in.color);
  // Every earlier cell has missed by the time the probe reaches the first free slot.
  assign append    = searching && (ID_CNT == count);

  always_comb begin
    probe_next       = probe_in;
    probe_next.hit   = probe_in.hit || match;
    probe_next.index = match ? ID_IDX : probe_in.index;
  end

  always_ff @(posedge clk) begin
    if (append) begin
      entry <= probe_in.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

endmodule

// ===== rtl/core/rpi_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: accepts pixels, launches probes into the cell row, keeps the
// fill count and overflow flag, and holds the output register. Uses rpi_pkg.
module rpi_ctrl #(
  parameter int PALETTE_SIZE = rpi_pkg::PALETTE_SIZE_DEFAULT,
  parameter int CNT_W        = $clog2(PALETTE_SIZE + 1)
) (
  input  logic              clk,
  input  logic              rst,
  rpi_pixel_if.sink         pixel,
  rpi_result_if.source      result,
  output rpi_pkg::probe_t   head,
  input  rpi_pkg::probe_t   tail,
  output logic [CNT_W-1:0]  count
);
  import rpi_pkg::*;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(PALETTE_SIZE);

  ctrl_state_t      state, state_next;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] count_inc;
  logic             ovf_seen, ovf_next, ovf_eff;
  probe_t           head_next;
  result_t          res, res_next;
  result_t          out_word, out_next;
  logic             out_valid, out_valid_next;

  assign count_inc = count + CNT_W'(1);
  assign count_eff = pixel.first_pixel ? '0 : count;
  assign ovf_eff   = pixel.first_pixel ? 1'b0 : ovf_seen;

  assign pixel.ready         = (state == ST_IDLE);
  assign result.valid        = out_valid;
  assign result.color_index  = out_word.color_index;
  assign result.is_new_color = out_word.is_new_color;
  assign result.overflow     = out_word.overflow;
  assign result.color_count  = out_word.color_count;

  always_comb begin
    state_next       = state;
    count_next       = count;
    ovf_next         = ovf_seen;
    head_next        = head;
    head_next.active = 1'b0;
    res_next         = res;
    out_next         = out_word;
    out_valid_next   = out_valid && !result.ready;
    case (state)
      ST_IDLE: begin
        if (pixel.valid) begin
          count_next = count_eff;
          ovf_next   = ovf_eff;
          if (ovf_eff) begin
            // Overflowed image: no lookup, the answer is known at once.
            res_next.color_index  = '0;
            res_next.is_new_color = 1'b0;
            res_next.overflow     = 1'b1;
            res_next.color_count  = CNT_OUT_W'(count_eff);
            state_next            = ST_RESULT;
          end else begin
            head_next.active = 1'b1;
            head_next.color  = {pixel.red, pixel.green, pixel.blue};
            head_next.hit    = 1'b0;
            head_next.index  = '0;
            state_next       = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (tail.active) begin
          if (tail.hit) begin
            res_next.color_index  = tail.index;
            res_next.is_new_color = 1'b0;
            res_next.overflow     = 1'b0;
            res_next.color_count  = CNT_OUT_W'(count);
          end else if (count < FULL) begin
            // The cell at the fill count has stored the colour on the way past.
            res_next.color_index  = IDX_OUT_W'(count);
            res_next.is_new_color = 1'b1;
            res_next.overflow     = 1'b0;
            res_next.color_count  = CNT_OUT_W'(count_inc);
            count_next            = count_inc;
          end else begin
            res_next.color_index  = '0;
            res_next.is_new_color = 1'b0;
            res_next.overflow     = 1'b1;
            res_next.color_count  = CNT_OUT_W'(count);
            ovf_next              = 1'b1;
          end
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid || result.ready) begin
          out_next       = res;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf_seen  <= 1'b0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      ovf_seen  <= ovf_next;
      head      <= head_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res      <= res_next;
    out_word <= out_next;
  end

endmodule

// ===== rtl/core/rgb_palette_indexer.sv =====
`timescale 1ns / 1ps
// RGB palette indexer, top level: a controller followed by a row of
// PALETTE_SIZE palette cells. Uses rpi_pkg, rpi_pixel_if, rpi_result_if.
//
// Each pixel word is looked up in a palette of up to PALETTE_SIZE distinct
// colours kept in order of first appearance; a known colour returns its index,
// a new one is appended and flagged, and a colour beyond the palette size sets
// a sticky overflow flag that forces index 0 until a pixel marked first_pixel
// clears the palette. A lookup is a probe that walks the row of cells one cell
// per clock, so one pixel is handled at a time: the probe is registered in the
// controller's head register and passes through every cell register; its answer
// is registered in the result register and then in the output register, and only
// then is the next pixel word accepted. A pixel of an image that has already
// overflowed skips the walk and goes straight to the result register. A new pixel word may be accepted
// while the previous result still waits in the output register, but the
// following result is only moved out once that register has been emptied, so
// a stalled result delays the pixel after it by as long as the stall lasts.
module rgb_palette_indexer #(
  parameter int PALETTE_SIZE = rpi_pkg::PALETTE_SIZE_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  rpi_pixel_if.sink     pixel,
  rpi_result_if.source  result
);
  import rpi_pkg::*;

  localparam int CNT_W = $clog2(PALETTE_SIZE + 1);

  probe_t           chain [PALETTE_SIZE+1];
  logic [CNT_W-1:0] count;

  rpi_ctrl #(
    .PALETTE_SIZE (PALETTE_SIZE),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel),
    .result (result),
    .head   (chain[0]),
    .tail   (chain[PALETTE_SIZE]),
    .count  (count)
  );

  for (genvar k = 0; k < PALETTE_SIZE; k++) begin : g_cell
    rpi_cell #(
      .CELL_ID (k),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (chain[k]),
      .count     (count),
      .probe_out (chain[k+1])
    );
  end

endmodule

// ===== rtl/core/rpi_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the RGB palette indexer, bound to its top level.
// Depends on rpi_pkg and rgb_palette_indexer.
module rpi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rpi_pkg::IDX_OUT_W-1:0] color_index,
  input logic                          is_new_color,
  input logic                          overflow,
  input logic [rpi_pkg::CNT_OUT_W-1:0] color_count
);
  import rpi_pkg::*;

  // A result word that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(color_index) &&
      $stable(is_new_color) && $stable(overflow) && $stable(color_count))
    else $error("result word changed while stalled");

  // Only one pixel is in flight: input is closed the cycle after an acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel accepted while another is being looked up");

  a_overflow_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> color_index == '0 && !is_new_color)
    else $error("overflowed result carries an index or a new colour");

  a_new_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_new_color |-> color_count != '0)
    else $error("new colour reported with an empty palette");

endmodule

bind rgb_palette_indexer rpi_checker u_rpi_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (pixel.valid),
  .in_ready     (pixel.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .color_index  (result.color_index),
  .is_new_color (result.is_new_color),
  .overflow     (result.overflow),
  .color_count  (result.color_count)
);
